[design/rtu_pkg.sv]
// Shared types, codes and the CRC-16 byte step for the RTU frame receiver.
`default_nettype none

package rtu_pkg;

  // Input transaction kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_TICK = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  // Result event codes
  localparam logic [2:0] EV_OK       = 3'd0;
  localparam logic [2:0] EV_SHORT    = 3'd1;
  localparam logic [2:0] EV_CRC_ERR  = 3'd2;
  localparam logic [2:0] EV_OVERFLOW = 3'd3;
  localparam logic [2:0] EV_READ     = 3'd4;

  // Frame checks and CRC constants
  localparam int unsigned  MIN_FRAME       = 5;
  localparam int unsigned  BYTE_BITS       = 8;
  localparam logic [15:0]  CRC_INIT        = 16'hFFFF;
  localparam logic [15:0]  CRC_POLY        = 16'hA001;
  localparam logic [15:0]  GAP_LIMIT_RESET = 16'd1750;
  localparam logic [15:0]  GAP_MAX         = 16'hFFFF;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] rx_byte;
    logic [7:0] read_index;
  } in_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [7:0]  unit_id;
    logic [7:0]  function_code;
    logic [7:0]  frame_length;
    logic [15:0] crc_value;
    logic [7:0]  read_data;
  } out_t;

  // One byte of the reflected Modbus CRC-16
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int i = 0; i < BYTE_BITS; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[design/rtu_frame_receiver.sv]
// RTU frame receiver: frames line bytes by tick gaps, checks length and CRC-16.
// Output path: the result is registered in stage one at the edge that accepts the input
//   transaction, then moves on into the output register once that register is free.
// Throughput: one input transaction per cycle while in_stall is low; bytes and ticks update
//   state at the accepting edge, and a read uses the one read port of the frame memory, registered once.
// Reset (rst, synchronous): idle, no frame open, gap_limit back to 1750.
//   The frame memory is not cleared; only written entries are meaningful.
`default_nettype none

module rtu_frame_receiver #(
  parameter int FRAME_MAX = 256
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire rtu_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output rtu_pkg::out_t      out_data,
  input  wire logic          cfg_we,
  input  wire logic [15:0]   cfg_wdata
);

  localparam int AW = $clog2(FRAME_MAX);
  localparam int PW = $clog2(FRAME_MAX + 1);
  localparam int LW = (PW > 8) ? PW : 8;
  localparam int XW = ((AW > 8) ? AW : 8) + 1;

  // Configuration
  logic [15:0] gap_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_limit <= rtu_pkg::GAP_LIMIT_RESET;
    end else if (cfg_we) begin
      gap_limit <= cfg_wdata;
    end
  end

  // Frame state
  logic          in_frame, in_frame_next;
  logic [PW-1:0] write_pos, write_pos_next;
  logic [15:0]   gap_count, gap_count_next;
  logic [15:0]   crc_lagged, crc_lagged_next;
  logic [15:0]   held_bytes, held_bytes_next;
  logic [7:0]    unit_id, unit_id_next;
  logic [7:0]    function_code, function_code_next;

  // Pipeline stage between accept and the output register
  logic          s1_valid;
  rtu_pkg::out_t s1_res, s1_res_next;
  rtu_pkg::out_t s1_out;
  logic          s1_rd_ok, s1_rd_ok_next;
  logic          res_fire;
  logic          s1_move;
  logic          in_accept;

  // Frame memory
  logic [7:0]    frame_store [FRAME_MAX];
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_q;

  // Combinational helpers
  logic [PW-1:0] wp_base, wp_inc;
  logic [15:0]   crc_base, held_base;
  logic [15:0]   gap_inc, lim;
  logic [XW-1:0] idx_x;
  logic [LW-1:0] len_full;

  assign s1_move   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !s1_move;
  assign in_accept = in_valid && !in_stall;

  assign wp_base   = in_frame ? write_pos  : '0;
  assign crc_base  = in_frame ? crc_lagged : rtu_pkg::CRC_INIT;
  assign held_base = in_frame ? held_bytes : 16'h0000;
  assign wp_inc    = wp_base + PW'(1);
  assign gap_inc   = (gap_count == rtu_pkg::GAP_MAX) ? gap_count : gap_count + 16'd1;
  assign lim       = (gap_limit == 16'd0) ? 16'd1 : gap_limit;
  assign idx_x     = XW'(in_data.read_index);
  assign len_full  = LW'(write_pos) - LW'(2);

  assign mem_waddr = wp_base[AW-1:0];
  assign mem_raddr = idx_x[AW-1:0];

  // Decide the state update and the result for the accepted transaction
  always_comb begin
    in_frame_next      = in_frame;
    write_pos_next     = write_pos;
    gap_count_next     = gap_count;
    crc_lagged_next    = crc_lagged;
    held_bytes_next    = held_bytes;
    unit_id_next       = unit_id;
    function_code_next = function_code;
    s1_res_next        = '0;
    s1_rd_ok_next      = 1'b0;
    res_fire           = 1'b0;
    mem_we             = 1'b0;
    mem_re             = 1'b0;

    if (in_accept) begin
      unique case (in_data.kind)
        rtu_pkg::KIND_BYTE: begin
          // Store the byte, feed the older held byte to the CRC
          gap_count_next  = 16'd0;
          mem_we          = 1'b1;
          crc_lagged_next = (wp_base >= PW'(2)) ?
                            rtu_pkg::crc_byte(crc_base, held_base[7:0]) : crc_base;
          held_bytes_next = {in_data.rx_byte, held_base[15:8]};
          if (wp_base == PW'(0)) begin
            unit_id_next = in_data.rx_byte;
          end
          if (wp_base == PW'(1)) begin
            function_code_next = in_data.rx_byte;
          end
          if (wp_inc == PW'(FRAME_MAX)) begin
            // Drop the frame once the buffer fills
            write_pos_next        = '0;
            in_frame_next         = 1'b0;
            res_fire              = 1'b1;
            s1_res_next.event_res = rtu_pkg::EV_OVERFLOW;
          end else begin
            write_pos_next = wp_inc;
            in_frame_next  = 1'b1;
          end
        end
        rtu_pkg::KIND_TICK: begin
          if (in_frame) begin
            if (gap_inc < lim) begin
              gap_count_next = gap_inc;
            end else begin
              // Close the frame and check it
              in_frame_next  = 1'b0;
              gap_count_next = 16'd0;
              write_pos_next = '0;
              res_fire       = 1'b1;
              if (write_pos < PW'(rtu_pkg::MIN_FRAME)) begin
                s1_res_next.event_res = rtu_pkg::EV_SHORT;
              end else if (crc_lagged != held_bytes) begin
                s1_res_next.event_res = rtu_pkg::EV_CRC_ERR;
              end else begin
                s1_res_next.event_res     = rtu_pkg::EV_OK;
                s1_res_next.unit_id       = unit_id;
                s1_res_next.function_code = function_code;
                s1_res_next.frame_length  = len_full[7:0];
                s1_res_next.crc_value     = held_bytes;
              end
            end
          end
        end
        rtu_pkg::KIND_READ: begin
          // Issue the memory read; data lands next cycle
          mem_re                = 1'b1;
          res_fire              = 1'b1;
          s1_rd_ok_next         = idx_x < XW'(FRAME_MAX);
          s1_res_next.event_res = rtu_pkg::EV_READ;
        end
        default: begin
          // Ignore unknown kinds
        end
      endcase
    end
  end

  // Advance frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame   <= 1'b0;
      write_pos  <= '0;
      gap_count  <= 16'd0;
      crc_lagged <= rtu_pkg::CRC_INIT;
      held_bytes <= 16'h0000;
    end else begin
      in_frame   <= in_frame_next;
      write_pos  <= write_pos_next;
      gap_count  <= gap_count_next;
      crc_lagged <= crc_lagged_next;
      held_bytes <= held_bytes_next;
    end
  end

  always_ff @(posedge clk) begin
    unit_id       <= unit_id_next;
    function_code <= function_code_next;
  end

  // Frame memory: one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_store[mem_waddr] <= in_data.rx_byte;
    end
    if (mem_re) begin
      mem_q <= frame_store[mem_raddr];
    end
  end

  // Hold the result in stage one until the output register frees up
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= res_fire;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_res   <= s1_res_next;
      s1_rd_ok <= s1_rd_ok_next;
    end
  end

  // Merge the read data into the staged result
  always_comb begin
    s1_out           = s1_res;
    s1_out.read_data = s1_rd_ok ? mem_q : 8'h00;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data <= s1_out;
    end
  end

`ifndef SYNTHESIS
  // An open frame never points past the buffer
  assert property (@(posedge clk) disable iff (rst)
    in_frame |-> (write_pos < PW'(FRAME_MAX)))
    else $error("write position beyond frame buffer");

  // Read data is only carried by read transactions
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.event_res != rtu_pkg::EV_READ) |-> (out_data.read_data == 8'h00))
    else $error("read data on a non-read result");

  // The gap counter rests at zero while idle
  assert property (@(posedge clk) disable iff (rst)
    !in_frame |-> (gap_count == 16'd0))
    else $error("gap counter running while idle");
`endif

endmodule

`default_nettype wire
